FILE: rtl/tmcs_pkg.sv
package tmcs_pkg;

  localparam int unsigned MIP_W     = 6;
  localparam int unsigned MIP_LIMIT = 32;

  localparam logic [7:0] FMT_UNKNOWN             = 8'd0;
  localparam logic [7:0] FMT_R32G32B32A32_FLOAT  = 8'd2;
  localparam logic [7:0] FMT_R16G16B16A16_FLOAT  = 8'd10;
  localparam logic [7:0] FMT_R16G16B16A16_UNORM  = 8'd11;
  localparam logic [7:0] FMT_R8G8B8A8_UNORM      = 8'd28;
  localparam logic [7:0] FMT_R8G8B8A8_UNORM_SRGB = 8'd29;
  localparam logic [7:0] FMT_R8G8_UNORM          = 8'd49;
  localparam logic [7:0] FMT_R16_FLOAT           = 8'd54;
  localparam logic [7:0] FMT_R8_UNORM            = 8'd61;
  localparam logic [7:0] FMT_A8_UNORM            = 8'd65;
  localparam logic [7:0] FMT_BC_FIRST            = 8'd71;
  localparam logic [7:0] FMT_BC1_UNORM           = 8'd71;
  localparam logic [7:0] FMT_BC1_UNORM_SRGB      = 8'd72;
  localparam logic [7:0] FMT_BC4_UNORM           = 8'd80;
  localparam logic [7:0] FMT_BC_LAST             = 8'd99;

  localparam logic [2:0] SHIFT_1B  = 3'd0;
  localparam logic [2:0] SHIFT_2B  = 3'd1;
  localparam logic [2:0] SHIFT_4B  = 3'd2;
  localparam logic [2:0] SHIFT_8B  = 3'd3;
  localparam logic [2:0] SHIFT_16B = 3'd4;

  typedef enum logic [1:0] {
    ST_OK,
    ST_ZERO_EXTENT,
    ST_MIP_LIMIT,
    ST_BAD_FORMAT
  } status_t;

  typedef enum logic [2:0] {
    MUL_NONE,
    MUL_EXT,
    MUL_MD_LO,
    MUL_MD_HI,
    MUL_SL_LO,
    MUL_SL_HI
  } mul_op_t;

  typedef enum logic [1:0] {
    ACC_HOLD,
    ACC_ADD_LO,
    ACC_ADD_HI,
    ACC_LOAD
  } acc_op_t;

  typedef enum logic [1:0] {
    RES_ERR,
    RES_MATCH,
    RES_MISS
  } res_kind_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_EV_INIT,
    S_LVL_A,
    S_LVL_B,
    S_LVL_C,
    S_LVL_END,
    S_SL_A,
    S_SL_B,
    S_SL_C,
    S_EV_DONE
  } state_t;

  typedef struct packed {
    logic      load;
    mul_op_t   mul_op;
    acc_op_t   acc_op;
    logic      ev_init;
    logic      lvl_adv;
    logic      ev_done;
    logic      step;
    logic      res_wr;
    res_kind_t res_kind;
  } dp_cmd_t;

  typedef struct packed {
    logic err;
    logic lvl_any;
    logic lvl_more;
    logic size_eq;
    logic can_step;
  } dp_sts_t;

  function automatic logic is_bc(logic [7:0] fmt);
    return (fmt >= FMT_BC_FIRST) && (fmt <= FMT_BC_LAST);
  endfunction

  function automatic logic [2:0] byte_shift(logic [7:0] fmt);
    logic [2:0] sh;
    if (is_bc(fmt)) begin
      if (fmt == FMT_BC1_UNORM || fmt == FMT_BC1_UNORM_SRGB || fmt == FMT_BC4_UNORM) begin
        sh = SHIFT_8B;
      end else begin
        sh = SHIFT_16B;
      end
    end else begin
      unique case (fmt)
        FMT_R32G32B32A32_FLOAT: sh = SHIFT_16B;
        FMT_R16G16B16A16_FLOAT,
        FMT_R16G16B16A16_UNORM: sh = SHIFT_8B;
        FMT_R8G8_UNORM,
        FMT_R16_FLOAT:          sh = SHIFT_2B;
        FMT_R8_UNORM,
        FMT_A8_UNORM:           sh = SHIFT_1B;
        default:                sh = SHIFT_4B;
      endcase
    end
    return sh;
  endfunction

endpackage

FILE: rtl/tmcs_dp.sv
module tmcs_dp #(
  parameter int MAX_LEVELS  = 32,
  parameter int MAX_RESCALE = 4
) (
  input  logic                      clk,
  input  tmcs_pkg::dp_cmd_t         cmd,
  output tmcs_pkg::dp_sts_t         sts,
  input  logic [7:0]                in_format_code,
  input  logic [31:0]               in_width,
  input  logic [31:0]               in_height,
  input  logic [31:0]               in_depth,
  input  logic [31:0]               in_mip_count,
  input  logic [31:0]               in_slice_count,
  input  logic [63:0]               in_payload_bytes,
  output logic [1:0]                out_status,
  output logic [63:0]               out_declared_bytes,
  output logic [31:0]               out_final_width,
  output logic [31:0]               out_final_height,
  output logic [tmcs_pkg::MIP_W-1:0] out_final_mip_count,
  output logic                      out_rescaled,
  output logic                      out_mismatch
);

  localparam int CNT_W = $clog2(MAX_LEVELS + 1);
  localparam int RS_W  = $clog2(MAX_RESCALE + 1);
  localparam int CMP_W = (CNT_W > tmcs_pkg::MIP_W) ? CNT_W : tmcs_pkg::MIP_W;

  logic                       bc_r;
  logic [2:0]                 bshift_r;
  logic [31:0]                w_r, h_r, d_r, sl_r;
  logic [tmcs_pkg::MIP_W-1:0] mips_r;
  logic [63:0]                pay_r;
  tmcs_pkg::status_t          err_r;

  logic [31:0]                cur_w_r, cur_h_r;
  logic [tmcs_pkg::MIP_W-1:0] cur_mips_r;
  logic [RS_W-1:0]            rs_r;

  logic [31:0]                lvl_w_r, lvl_h_r, lvl_d_r;
  logic [CNT_W-1:0]           lvl_cnt_r;

  logic [63:0]                mul_r, lv_r, sum_r, decl_r;

  tmcs_pkg::status_t          err_nxt;
  logic [31:0]                mw, mh, md, bw, bh, op_a, op_b;
  logic [63:0]                lv_nxt, decl_val, sum_nxt;
  logic [CMP_W-1:0]           lim;

  always_comb begin
    if (in_width == 32'd0 || in_height == 32'd0) begin
      err_nxt = tmcs_pkg::ST_ZERO_EXTENT;
    end else if (in_mip_count > 32'(tmcs_pkg::MIP_LIMIT)) begin
      err_nxt = tmcs_pkg::ST_MIP_LIMIT;
    end else if (in_format_code == tmcs_pkg::FMT_UNKNOWN) begin
      err_nxt = tmcs_pkg::ST_BAD_FORMAT;
    end else begin
      err_nxt = tmcs_pkg::ST_OK;
    end
  end

  assign mw     = (lvl_w_r == 32'd0) ? 32'd1 : lvl_w_r;
  assign mh     = (lvl_h_r == 32'd0) ? 32'd1 : lvl_h_r;
  assign md     = (lvl_d_r == 32'd0) ? 32'd1 : lvl_d_r;
  assign bw     = {2'b00, mw[31:2]} + 32'(|mw[1:0]);
  assign bh     = {2'b00, mh[31:2]} + 32'(|mh[1:0]);
  assign lv_nxt = mul_r << bshift_r;

  always_comb begin
    op_a = 32'd0;
    op_b = 32'd0;
    unique case (cmd.mul_op)
      tmcs_pkg::MUL_NONE: begin
        op_a = 32'd0;
        op_b = 32'd0;
      end
      tmcs_pkg::MUL_EXT: begin
        op_a = bc_r ? bw : mw;
        op_b = bc_r ? bh : mh;
      end
      tmcs_pkg::MUL_MD_LO: begin
        op_a = lv_nxt[31:0];
        op_b = md;
      end
      tmcs_pkg::MUL_MD_HI: begin
        op_a = lv_r[63:32];
        op_b = md;
      end
      tmcs_pkg::MUL_SL_LO: begin
        op_a = sum_r[31:0];
        op_b = sl_r;
      end
      tmcs_pkg::MUL_SL_HI: begin
        op_a = sum_r[63:32];
        op_b = sl_r;
      end
      default: begin
        op_a = 32'd0;
        op_b = 32'd0;
      end
    endcase
  end

  always_comb begin
    unique case (cmd.acc_op)
      tmcs_pkg::ACC_HOLD:   sum_nxt = sum_r;
      tmcs_pkg::ACC_ADD_LO: sum_nxt = sum_r + mul_r;
      tmcs_pkg::ACC_ADD_HI: sum_nxt = sum_r + {mul_r[31:0], 32'd0};
      tmcs_pkg::ACC_LOAD:   sum_nxt = mul_r;
      default:              sum_nxt = sum_r;
    endcase
  end

  assign lim = (CMP_W'(cur_mips_r) < CMP_W'(MAX_LEVELS)) ? CMP_W'(cur_mips_r)
                                                          : CMP_W'(MAX_LEVELS);
  assign decl_val = (rs_r == '0) ? sum_r : decl_r;

  assign sts.err      = (err_r != tmcs_pkg::ST_OK);
  assign sts.lvl_any  = (lim != '0);
  assign sts.lvl_more = ((CMP_W'(lvl_cnt_r) + CMP_W'(1)) < lim);
  assign sts.size_eq  = (sum_r == pay_r);
  assign sts.can_step = (rs_r < RS_W'(MAX_RESCALE)) && !cur_w_r[31] && !cur_h_r[31];

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      bc_r     <= tmcs_pkg::is_bc(in_format_code);
      bshift_r <= tmcs_pkg::byte_shift(in_format_code);
      w_r      <= in_width;
      h_r      <= in_height;
      d_r      <= in_depth;
      sl_r     <= (in_slice_count == 32'd0) ? 32'd1 : in_slice_count;
      mips_r   <= in_mip_count[tmcs_pkg::MIP_W-1:0];
      pay_r    <= in_payload_bytes;
      err_r    <= err_nxt;
      cur_w_r    <= in_width;
      cur_h_r    <= in_height;
      cur_mips_r <= in_mip_count[tmcs_pkg::MIP_W-1:0];
      rs_r       <= '0;
    end else if (cmd.step) begin
      cur_w_r    <= {cur_w_r[30:0], 1'b0};
      cur_h_r    <= {cur_h_r[30:0], 1'b0};
      cur_mips_r <= cur_mips_r + tmcs_pkg::MIP_W'(1);
      rs_r       <= rs_r + RS_W'(1);
    end

    if (cmd.ev_init) begin
      lvl_w_r   <= cur_w_r;
      lvl_h_r   <= cur_h_r;
      lvl_d_r   <= d_r;
      lvl_cnt_r <= '0;
    end else if (cmd.lvl_adv) begin
      lvl_w_r   <= {1'b0, lvl_w_r[31:1]};
      lvl_h_r   <= {1'b0, lvl_h_r[31:1]};
      lvl_d_r   <= {1'b0, lvl_d_r[31:1]};
      lvl_cnt_r <= lvl_cnt_r + CNT_W'(1);
    end

    if (cmd.ev_init) begin
      mul_r <= 64'd0;
      sum_r <= 64'd0;
    end else begin
      if (cmd.mul_op != tmcs_pkg::MUL_NONE) begin
        mul_r <= {32'd0, op_a} * {32'd0, op_b};
      end
      sum_r <= sum_nxt;
    end

    if (cmd.mul_op == tmcs_pkg::MUL_MD_LO) begin
      lv_r <= lv_nxt;
    end

    if (cmd.ev_done && rs_r == '0) begin
      decl_r <= sum_r;
    end

    if (cmd.res_wr) begin
      unique case (cmd.res_kind)
        tmcs_pkg::RES_ERR: begin
          out_status          <= err_r;
          out_declared_bytes  <= 64'd0;
          out_final_width     <= 32'd0;
          out_final_height    <= 32'd0;
          out_final_mip_count <= '0;
          out_rescaled        <= 1'b0;
          out_mismatch        <= 1'b0;
        end
        tmcs_pkg::RES_MATCH: begin
          out_status          <= tmcs_pkg::ST_OK;
          out_declared_bytes  <= decl_val;
          out_final_width     <= cur_w_r;
          out_final_height    <= cur_h_r;
          out_final_mip_count <= cur_mips_r;
          out_rescaled        <= (rs_r != '0);
          out_mismatch        <= 1'b0;
        end
        default: begin
          out_status          <= tmcs_pkg::ST_OK;
          out_declared_bytes  <= decl_val;
          out_final_width     <= w_r;
          out_final_height    <= h_r;
          out_final_mip_count <= mips_r;
          out_rescaled        <= 1'b0;
          out_mismatch        <= 1'b1;
        end
      endcase
    end
  end

endmodule

FILE: rtl/tmcs_ctrl.sv
module tmcs_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  tmcs_pkg::dp_sts_t sts,
  output tmcs_pkg::dp_cmd_t cmd
);

  tmcs_pkg::state_t state_r, state_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             out_free;

  assign out_free  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tmcs_pkg::S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    in_ready     = 1'b0;
    cmd          = '0;
    cmd.mul_op   = tmcs_pkg::MUL_NONE;
    cmd.acc_op   = tmcs_pkg::ACC_HOLD;
    cmd.res_kind = tmcs_pkg::RES_ERR;

    unique case (state_r)
      tmcs_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = tmcs_pkg::S_CHECK;
        end
      end
      tmcs_pkg::S_CHECK: begin
        if (!sts.err) begin
          state_nxt = tmcs_pkg::S_EV_INIT;
        end else if (out_free) begin
          cmd.res_wr   = 1'b1;
          cmd.res_kind = tmcs_pkg::RES_ERR;
          state_nxt    = tmcs_pkg::S_IDLE;
        end
      end
      tmcs_pkg::S_EV_INIT: begin
        cmd.ev_init = 1'b1;
        state_nxt   = sts.lvl_any ? tmcs_pkg::S_LVL_A : tmcs_pkg::S_LVL_END;
      end
      tmcs_pkg::S_LVL_A: begin
        cmd.mul_op = tmcs_pkg::MUL_EXT;
        cmd.acc_op = tmcs_pkg::ACC_ADD_HI;
        state_nxt  = tmcs_pkg::S_LVL_B;
      end
      tmcs_pkg::S_LVL_B: begin
        cmd.mul_op = tmcs_pkg::MUL_MD_LO;
        state_nxt  = tmcs_pkg::S_LVL_C;
      end
      tmcs_pkg::S_LVL_C: begin
        cmd.mul_op  = tmcs_pkg::MUL_MD_HI;
        cmd.acc_op  = tmcs_pkg::ACC_ADD_LO;
        cmd.lvl_adv = 1'b1;
        state_nxt   = sts.lvl_more ? tmcs_pkg::S_LVL_A : tmcs_pkg::S_LVL_END;
      end
      tmcs_pkg::S_LVL_END: begin
        cmd.acc_op = tmcs_pkg::ACC_ADD_HI;
        state_nxt  = tmcs_pkg::S_SL_A;
      end
      tmcs_pkg::S_SL_A: begin
        cmd.mul_op = tmcs_pkg::MUL_SL_LO;
        state_nxt  = tmcs_pkg::S_SL_B;
      end
      tmcs_pkg::S_SL_B: begin
        cmd.mul_op = tmcs_pkg::MUL_SL_HI;
        cmd.acc_op = tmcs_pkg::ACC_LOAD;
        state_nxt  = tmcs_pkg::S_SL_C;
      end
      tmcs_pkg::S_SL_C: begin
        cmd.acc_op = tmcs_pkg::ACC_ADD_HI;
        state_nxt  = tmcs_pkg::S_EV_DONE;
      end
      tmcs_pkg::S_EV_DONE: begin
        cmd.ev_done = 1'b1;
        if (sts.size_eq) begin
          if (out_free) begin
            cmd.res_wr   = 1'b1;
            cmd.res_kind = tmcs_pkg::RES_MATCH;
            state_nxt    = tmcs_pkg::S_IDLE;
          end
        end else if (sts.can_step) begin
          cmd.step  = 1'b1;
          state_nxt = tmcs_pkg::S_EV_INIT;
        end else if (out_free) begin
          cmd.res_wr   = 1'b1;
          cmd.res_kind = tmcs_pkg::RES_MISS;
          state_nxt    = tmcs_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = tmcs_pkg::S_IDLE;
      end
    endcase

    if (cmd.res_wr) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

endmodule

FILE: rtl/texture_mip_chain_sizer_unit.sv
// Texture mip chain sizer.
// Input channel (in_valid/in_ready): one texture descriptor per transaction,
// format code, extents, mip and slice counts, and the real payload size.
// Output channel (out_valid/out_ready): one result per descriptor: status,
// declared chain size, final extents and mip count, rescaled and mismatch.
// One descriptor is worked on at a time; in_ready is high while the unit is
// free. A descriptor with a header error skips the size evaluation.
// Otherwise each size evaluation sums L levels (at most MAX_LEVELS), with
// all products passing through one shared 32x32 multiplier, three products
// per level plus two for the slice count.
// The declared size is one evaluation; each rescale attempt adds one more,
// up to MAX_RESCALE attempts, plus the capture and the header check.
// The result sits in an output register, so a new descriptor is taken while
// the previous result waits. If the receiver stalls and a second result is
// ready, the unit holds it and stops taking input until the first is taken.
// Reset (rst_n low, synchronous) returns the unit to idle and drops any
// pending result.
module texture_mip_chain_sizer_unit #(
  parameter int MAX_LEVELS  = 32,
  parameter int MAX_RESCALE = 4
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [7:0]                 in_format_code,
  input  logic [31:0]                in_width,
  input  logic [31:0]                in_height,
  input  logic [31:0]                in_depth,
  input  logic [31:0]                in_mip_count,
  input  logic [31:0]                in_slice_count,
  input  logic [63:0]                in_payload_bytes,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [1:0]                 out_status,
  output logic [63:0]                out_declared_bytes,
  output logic [31:0]                out_final_width,
  output logic [31:0]                out_final_height,
  output logic [tmcs_pkg::MIP_W-1:0] out_final_mip_count,
  output logic                       out_rescaled,
  output logic                       out_mismatch
);

  tmcs_pkg::dp_cmd_t cmd;
  tmcs_pkg::dp_sts_t sts;

  tmcs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  tmcs_dp #(
    .MAX_LEVELS  (MAX_LEVELS),
    .MAX_RESCALE (MAX_RESCALE)
  ) u_dp (
    .clk                 (clk),
    .cmd                 (cmd),
    .sts                 (sts),
    .in_format_code      (in_format_code),
    .in_width            (in_width),
    .in_height           (in_height),
    .in_depth            (in_depth),
    .in_mip_count        (in_mip_count),
    .in_slice_count      (in_slice_count),
    .in_payload_bytes    (in_payload_bytes),
    .out_status          (out_status),
    .out_declared_bytes  (out_declared_bytes),
    .out_final_width     (out_final_width),
    .out_final_height    (out_final_height),
    .out_final_mip_count (out_final_mip_count),
    .out_rescaled        (out_rescaled),
    .out_mismatch        (out_mismatch)
  );

endmodule

FILE: rtl/tmcs_checker.sv
module tmcs_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [1:0]                 out_status,
  input logic [63:0]                out_declared_bytes,
  input logic [31:0]                out_final_width,
  input logic [31:0]                out_final_height,
  input logic [tmcs_pkg::MIP_W-1:0] out_final_mip_count,
  input logic                       out_rescaled,
  input logic                       out_mismatch
);

  a_reset_drops_result: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result still valid after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_declared_bytes))
    else $error("stalled result changed or dropped");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second transaction taken before first is done");

  a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != 2'(tmcs_pkg::ST_OK) |->
      out_declared_bytes == 64'd0 && out_final_width == 32'd0 &&
      out_final_height == 32'd0 && !out_rescaled && !out_mismatch)
    else $error("error result carries nonzero fields");

  a_rescale_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_rescaled |->
      !out_mismatch && out_status == 2'(tmcs_pkg::ST_OK) && out_final_mip_count != '0)
    else $error("rescaled result inconsistent");

endmodule

bind texture_mip_chain_sizer_unit tmcs_checker u_tmcs_checker (.*);
